/* rtl/plti_pkg.sv */
package plti_pkg;

    // Fixed field widths
    localparam int unsigned DATA_W     = 32;
    localparam int unsigned INDEX_W    = 6;
    localparam int unsigned COUNT_W    = 7;
    localparam int unsigned GAP_W      = 16;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned STATUS_W   = 3;

    localparam logic [GAP_W-1:0] MIN_GAP_RESET = GAP_W'(1);

    // Item kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Configuration register indexes
    typedef enum logic [0:0] {
        REG_POINTS_IN_USE = 1'b0,
        REG_MIN_GAP       = 1'b1
    } cfg_index_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_INTERP     = 3'd0,
        ST_CLAMP_LOW  = 3'd1,
        ST_CLAMP_HIGH = 3'd2,
        ST_EMPTY      = 3'd3,
        ST_NARROW     = 3'd4
    } status_t;

    // Table read address source
    typedef enum logic [1:0] {
        RD_ZERO = 2'd0,
        RD_LAST = 2'd1,
        RD_NEXT = 2'd2
    } rd_sel_t;

    // Result value source
    typedef enum logic [1:0] {
        RES_ZERO = 2'd0,
        RES_READ = 2'd1,
        RES_LEFT = 2'd2,
        RES_CALC = 2'd3
    } res_sel_t;

    // Controller to datapath commands
    typedef struct packed {
        logic     wr_point;
        logic     start;
        rd_sel_t  rd_sel;
        logic     load_left;
        logic     adv_idx;
        logic     load_right;
        logic     div_init;
        logic     div_step;
        logic     mul_step;
        logic     round_step;
        logic     load_res;
        res_sel_t res_sel;
        status_t  res_status;
        logic     push;
    } plti_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic empty;
        logic q_le_rd;
        logic q_ge_rd;
        logic narrow;
        logic cnt_zero;
        logic out_free;
    } plti_stat_t;

endpackage

/* rtl/piecewise_linear_table_interpolator_unit.sv */
// Piecewise linear table interpolator.
// Input channel (in_valid/in_ready): kind selects a breakpoint write (stores
// point_abscissa/point_ordinate at point_index, no result) or a query at
// query_position. Output channel (out_valid/out_ready) returns
// interpolated_value and status, one transaction per query.
// Configuration: cfg_we with cfg_index/cfg_data sets points_in_use and min_gap.
// A write is accepted while idle; writes can follow each other every cycle
// while no query is in progress. A query is handled alone: it reads the
// first and the last breakpoint for the clamps, then scans the table, one
// breakpoint per cycle through the registered read port; an interpolation
// then runs a restoring divider and a shift-add multiplier. in_ready returns
// the cycle after the result moves into the output register.
// A stalled receiver holds the result in the output register; the next item
// is still accepted, and a finished query waits until that register frees.
// Reset clears the controller, the output valid and the registers
// (points_in_use 0, min_gap 1); table contents are undefined until written.
module piecewise_linear_table_interpolator_unit #(
    parameter int unsigned TABLE_DEPTH   = 64,
    parameter int unsigned FRACTION_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               kind,
    input  logic [plti_pkg::INDEX_W-1:0]       point_index,
    input  logic signed [plti_pkg::DATA_W-1:0] point_abscissa,
    input  logic signed [plti_pkg::DATA_W-1:0] point_ordinate,
    input  logic signed [plti_pkg::DATA_W-1:0] query_position,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [plti_pkg::DATA_W-1:0] interpolated_value,
    output logic [plti_pkg::STATUS_W-1:0]      status,
    input  logic                               cfg_we,
    input  plti_pkg::cfg_index_t               cfg_index,
    input  logic [plti_pkg::CFG_DATA_W-1:0]    cfg_data
);

    import plti_pkg::*;

    plti_cmd_t  cmd;
    plti_stat_t stat;

    // Sequencer
    plti_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .kind     (kind),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Table, arithmetic and output register
    plti_dp #(
        .TABLE_DEPTH   (TABLE_DEPTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .point_index        (point_index),
        .point_abscissa     (point_abscissa),
        .point_ordinate     (point_ordinate),
        .query_position     (query_position),
        .out_ready          (out_ready),
        .out_valid          (out_valid),
        .interpolated_value (interpolated_value),
        .status             (status),
        .cmd                (cmd),
        .stat               (stat)
    );

endmodule

/* rtl/plti_ram.sv */
module plti_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/plti_dp.sv */
module plti_dp #(
    parameter int unsigned TABLE_DEPTH   = 64,
    parameter int unsigned FRACTION_BITS = 16
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_we,
    input  plti_pkg::cfg_index_t                    cfg_index,
    input  logic [plti_pkg::CFG_DATA_W-1:0]         cfg_data,
    input  logic [plti_pkg::INDEX_W-1:0]            point_index,
    input  logic signed [plti_pkg::DATA_W-1:0]      point_abscissa,
    input  logic signed [plti_pkg::DATA_W-1:0]      point_ordinate,
    input  logic signed [plti_pkg::DATA_W-1:0]      query_position,
    input  logic                                    out_ready,
    output logic                                    out_valid,
    output logic signed [plti_pkg::DATA_W-1:0]      interpolated_value,
    output logic [plti_pkg::STATUS_W-1:0]           status,
    input  plti_pkg::plti_cmd_t                     cmd,
    output plti_pkg::plti_stat_t                    stat
);

    import plti_pkg::*;

    localparam int unsigned AW  = $clog2(TABLE_DEPTH);
    localparam int unsigned CW  = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned NW  = (CW > COUNT_W) ? CW : COUNT_W;
    localparam int unsigned QW  = FRACTION_BITS + 2;
    localparam int unsigned TW  = FRACTION_BITS + 1;
    localparam int unsigned PW  = DATA_W + FRACTION_BITS;
    localparam int unsigned KW  = $clog2(QW);
    localparam int unsigned DW  = DATA_W + 1;
    localparam int unsigned EW  = DATA_W + 2;

    // Configuration registers
    logic [COUNT_W-1:0] points_in_use_reg;
    logic [GAP_W-1:0]   min_gap_reg;

    // Scan state
    logic [AW-1:0]            idx_reg;
    logic [AW-1:0]            last_idx_reg;
    logic signed [DATA_W-1:0] q_reg;
    logic signed [DATA_W-1:0] x0_reg;
    logic signed [DATA_W-1:0] y0_reg;
    logic signed [DATA_W-1:0] x1_reg;
    logic signed [DW-1:0]     dy_reg;

    // Divider, multiplier, rounding
    logic [DW-1:0]     rem_reg;
    logic [DATA_W-1:0] dvs_reg;
    logic [QW-1:0]     quot_reg;
    logic [KW-1:0]     cnt_reg;
    logic [TW-1:0]     t_reg;
    logic [PW-1:0]     acc_reg;
    logic [DATA_W-1:0] mag_reg;
    logic              neg_reg;
    logic [DATA_W-1:0] step_reg;

    // Result staging and output register
    logic signed [DATA_W-1:0] res_val_reg;
    status_t                  res_status_reg;
    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] out_val_reg;
    logic [STATUS_W-1:0]      out_status_reg;

    logic [NW-1:0]            n_full;
    logic [NW-1:0]            depth_c;
    logic [NW-1:0]            n_eff;
    logic [AW-1:0]            last_idx_w;
    logic                     wr_ok;
    logic [AW-1:0]            waddr;
    logic [AW-1:0]            raddr;
    logic [DATA_W-1:0]        rdata_x;
    logic [DATA_W-1:0]        rdata_y;
    logic signed [DW-1:0]     dx;
    logic signed [DW-1:0]     num;
    logic signed [DW-1:0]     gap_s;
    logic [DATA_W-1:0]        mag_w;
    logic [DW-1:0]            dvs_ext;
    logic                     div_ge;
    logic [DW-1:0]            rem_sub;
    logic [QW-1:0]            quot_next;
    logic [QW:0]              quot_inc;
    logic [TW-1:0]            t_w;
    logic [PW-1:0]            round_sum;
    logic signed [EW-1:0]     y0_ext;
    logic signed [EW-1:0]     step_ext;
    logic signed [EW-1:0]     calc_ext;
    logic signed [DATA_W-1:0] calc_sat;
    logic signed [DATA_W-1:0] res_val_w;

    // Effective breakpoint count and last index
    assign n_full     = NW'(points_in_use_reg);
    assign depth_c    = NW'(TABLE_DEPTH);
    assign n_eff      = (n_full > depth_c) ? depth_c : n_full;
    assign last_idx_w = AW'(n_eff - NW'(1));

    // Table write, ignored beyond the depth
    assign wr_ok = cmd.wr_point && (NW'(point_index) < depth_c);
    assign waddr = AW'(point_index);

    // Read address select
    always_comb
    begin
        case (cmd.rd_sel)
            RD_ZERO: raddr = '0;
            RD_LAST: raddr = last_idx_reg;
            RD_NEXT: raddr = idx_reg + AW'(1);
            default: raddr = '0;
        endcase
    end

    plti_ram #(
        .WIDTH (DATA_W),
        .DEPTH (TABLE_DEPTH)
    ) u_abscissa_ram (
        .clk   (clk),
        .we    (wr_ok),
        .waddr (waddr),
        .wdata (point_abscissa),
        .raddr (raddr),
        .rdata (rdata_x)
    );

    plti_ram #(
        .WIDTH (DATA_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ordinate_ram (
        .clk   (clk),
        .we    (wr_ok),
        .waddr (waddr),
        .wdata (point_ordinate),
        .raddr (raddr),
        .rdata (rdata_y)
    );

    // Segment checks
    assign dx    = $signed({x1_reg[DATA_W-1], x1_reg}) - $signed({x0_reg[DATA_W-1], x0_reg});
    assign num   = $signed({q_reg[DATA_W-1], q_reg}) - $signed({x0_reg[DATA_W-1], x0_reg});
    assign gap_s = $signed({{(DW - GAP_W){1'b0}}, min_gap_reg});
    assign mag_w = dy_reg[DW-1] ? DATA_W'(-dy_reg) : DATA_W'(dy_reg);

    // Restoring divider step, one quotient bit a cycle
    assign dvs_ext   = {1'b0, dvs_reg};
    assign div_ge    = rem_reg >= dvs_ext;
    assign rem_sub   = div_ge ? (rem_reg - dvs_ext) : rem_reg;
    assign quot_next = {quot_reg[QW-2:0], div_ge};
    // Round half up: halve the quotient that carries one extra bit
    assign quot_inc  = {1'b0, quot_next} + (QW + 1)'(1);
    assign t_w       = TW'(quot_inc >> 1);

    // Product rounding and final add
    assign round_sum = acc_reg + (PW'(1) << (FRACTION_BITS - 1));
    assign y0_ext    = EW'(y0_reg);
    assign step_ext  = $signed({2'b00, step_reg});
    assign calc_ext  = neg_reg ? (y0_ext - step_ext) : (y0_ext + step_ext);

    // Saturate to the 32-bit range
    always_comb
    begin
        if (!calc_ext[EW-1] && (|calc_ext[EW-2:DATA_W-1]))
        begin
            calc_sat = {1'b0, {(DATA_W - 1){1'b1}}};
        end
        else if (calc_ext[EW-1] && !(&calc_ext[EW-2:DATA_W-1]))
        begin
            calc_sat = {1'b1, {(DATA_W - 1){1'b0}}};
        end
        else
        begin
            calc_sat = calc_ext[DATA_W-1:0];
        end
    end

    // Result value select
    always_comb
    begin
        case (cmd.res_sel)
            RES_ZERO: res_val_w = '0;
            RES_READ: res_val_w = rdata_y;
            RES_LEFT: res_val_w = y0_reg;
            RES_CALC: res_val_w = calc_sat;
            default:  res_val_w = '0;
        endcase
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            points_in_use_reg <= '0;
            min_gap_reg       <= MIN_GAP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_POINTS_IN_USE: points_in_use_reg <= cfg_data[COUNT_W-1:0];
                REG_MIN_GAP:       min_gap_reg       <= cfg_data[GAP_W-1:0];
            endcase
        end
    end

    // Scan index and iteration counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (cmd.start)
            begin
                idx_reg <= '0;
            end
            else if (cmd.adv_idx)
            begin
                idx_reg <= idx_reg + AW'(1);
            end

            if (cmd.div_init)
            begin
                cnt_reg <= KW'(QW - 1);
            end
            else if (cmd.div_step && stat.cnt_zero)
            begin
                cnt_reg <= KW'(TW - 1);
            end
            else if (cmd.div_step || cmd.mul_step)
            begin
                cnt_reg <= cnt_reg - KW'(1);
            end
        end
    end

    // Datapath payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            q_reg        <= query_position;
            last_idx_reg <= last_idx_w;
        end
        if (cmd.load_left)
        begin
            x0_reg <= rdata_x;
            y0_reg <= rdata_y;
        end
        if (cmd.load_right)
        begin
            x1_reg <= rdata_x;
            dy_reg <= $signed({rdata_y[DATA_W-1], rdata_y}) - $signed({y0_reg[DATA_W-1], y0_reg});
        end
        if (cmd.div_init)
        begin
            rem_reg  <= {1'b0, num[DATA_W-1:0]};
            dvs_reg  <= dx[DATA_W-1:0];
            quot_reg <= '0;
            mag_reg  <= mag_w;
            neg_reg  <= dy_reg[DW-1];
        end
        if (cmd.div_step)
        begin
            rem_reg  <= {rem_sub[DATA_W-1:0], 1'b0};
            quot_reg <= quot_next;
            if (stat.cnt_zero)
            begin
                t_reg   <= t_w;
                acc_reg <= '0;
            end
        end
        // Shift-add multiply, MSB of the fraction first
        if (cmd.mul_step)
        begin
            acc_reg <= (acc_reg << 1) + (t_reg[TW-1] ? PW'(mag_reg) : PW'(0));
            t_reg   <= t_reg << 1;
        end
        if (cmd.round_step)
        begin
            step_reg <= round_sum[PW-1:FRACTION_BITS];
        end
        if (cmd.load_res)
        begin
            res_val_reg    <= res_val_w;
            res_status_reg <= cmd.res_status;
        end
        if (cmd.push)
        begin
            out_val_reg    <= res_val_reg;
            out_status_reg <= res_status_reg;
        end
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Status to controller
    always_comb
    begin
        stat.empty    = (n_full == '0);
        stat.q_le_rd  = q_reg <= $signed(rdata_x);
        stat.q_ge_rd  = q_reg >= $signed(rdata_x);
        stat.narrow   = (dx < gap_s) || (dx <= $signed(DW'(0))) || (q_reg <= x0_reg);
        stat.cnt_zero = (cnt_reg == '0);
        stat.out_free = !out_valid_reg || out_ready;
    end

    assign out_valid          = out_valid_reg;
    assign interpolated_value = out_val_reg;
    assign status             = out_status_reg;

endmodule

/* rtl/plti_ctrl.sv */
module plti_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 kind,
    output logic                 in_ready,
    input  plti_pkg::plti_stat_t stat,
    output plti_pkg::plti_cmd_t  cmd
);

    import plti_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_FIRST = 10'b00_0000_0010,
        S_LAST  = 10'b00_0000_0100,
        S_SCAN  = 10'b00_0000_1000,
        S_SEG   = 10'b00_0001_0000,
        S_DIV   = 10'b00_0010_0000,
        S_MUL   = 10'b00_0100_0000,
        S_RND   = 10'b00_1000_0000,
        S_FIN   = 10'b01_0000_0000,
        S_DONE  = 10'b10_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Sequencer
    always_comb
    begin
        cmd        = '0;
        in_ready   = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid && (kind == KIND_WRITE))
                begin
                    cmd.wr_point = 1'b1;
                end
                else if (in_valid)
                begin
                    cmd.start = 1'b1;
                    if (stat.empty)
                    begin
                        cmd.load_res   = 1'b1;
                        cmd.res_sel    = RES_ZERO;
                        cmd.res_status = ST_EMPTY;
                        state_next     = S_DONE;
                    end
                    else
                    begin
                        cmd.rd_sel = RD_ZERO;
                        state_next = S_FIRST;
                    end
                end
            end
            // First breakpoint on the read port
            S_FIRST:
            begin
                cmd.load_left = 1'b1;
                if (stat.q_le_rd)
                begin
                    cmd.load_res   = 1'b1;
                    cmd.res_sel    = RES_READ;
                    cmd.res_status = ST_CLAMP_LOW;
                    state_next     = S_DONE;
                end
                else
                begin
                    cmd.rd_sel = RD_LAST;
                    state_next = S_LAST;
                end
            end
            // Last breakpoint on the read port
            S_LAST:
            begin
                if (stat.q_ge_rd)
                begin
                    cmd.load_res   = 1'b1;
                    cmd.res_sel    = RES_READ;
                    cmd.res_status = ST_CLAMP_HIGH;
                    state_next     = S_DONE;
                end
                else
                begin
                    cmd.rd_sel  = RD_NEXT;
                    cmd.adv_idx = 1'b1;
                    state_next  = S_SCAN;
                end
            end
            // Walk until the right abscissa reaches the position
            S_SCAN:
            begin
                if (stat.q_le_rd)
                begin
                    cmd.load_right = 1'b1;
                    state_next     = S_SEG;
                end
                else
                begin
                    cmd.load_left = 1'b1;
                    cmd.rd_sel    = RD_NEXT;
                    cmd.adv_idx   = 1'b1;
                end
            end
            S_SEG:
            begin
                if (stat.narrow)
                begin
                    cmd.load_res   = 1'b1;
                    cmd.res_sel    = RES_LEFT;
                    cmd.res_status = ST_NARROW;
                    state_next     = S_DONE;
                end
                else
                begin
                    cmd.div_init = 1'b1;
                    state_next   = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.cnt_zero)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul_step = 1'b1;
                if (stat.cnt_zero)
                begin
                    state_next = S_RND;
                end
            end
            S_RND:
            begin
                cmd.round_step = 1'b1;
                state_next     = S_FIN;
            end
            S_FIN:
            begin
                cmd.load_res   = 1'b1;
                cmd.res_sel    = RES_CALC;
                cmd.res_status = ST_INTERP;
                state_next     = S_DONE;
            end
            // Hand the result to the output register once it is free
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/plti_props.sv */
module plti_props (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_ready,
    input logic                               kind,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic signed [plti_pkg::DATA_W-1:0] interpolated_value,
    input logic [plti_pkg::STATUS_W-1:0]      status
);

    import plti_pkg::*;

    // Stalled result transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(interpolated_value) && $stable(status))
        else $error("result changed while stalled");

    // Empty table answers zero
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_EMPTY) |-> interpolated_value == '0)
        else $error("empty table result is not zero");

    // An accepted query takes in_ready low (the design keeps it low until the query completes)
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (kind == KIND_QUERY) |=> !in_ready)
        else $error("input accepted during a query");

    // A breakpoint write never produces a result
    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (kind == KIND_WRITE) |=> ##1 !$rose(out_valid))
        else $error("result appeared after a write");

    // A result never appears right after its query
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result appeared too early");

endmodule

bind piecewise_linear_table_interpolator_unit plti_props u_plti_props (.*);
